// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk, disabled while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same check with a named clock and reset.
`define ASSERT_CLK_RST(label, ck, rn, prop, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

`endif

// ===== design/alfr_pkg.sv =====
// Shared constants, types and helpers for the lagged Fibonacci word source.
// No dependencies.
`timescale 1ns / 1ps

package alfr_pkg;

	localparam int unsigned TABLE_DEPTH = 55;
	localparam int unsigned LAG_OFFSET  = 20;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]  idx_t;

	// write port bundle for the table memory
	typedef struct packed {
		logic  en;
		idx_t  addr;
		word_t data;
	} mem_wr_t;

	localparam word_t RESET_WORDS [TABLE_DEPTH] = '{
		32'o35340171546, 32'o10401501101, 32'o22364657325, 32'o24130436022,
		32'o02167303062, 32'o37570375137, 32'o37210607110, 32'o16272055420,
		32'o23011770546, 32'o17143426366, 32'o14753657433, 32'o21657231332,
		32'o23553406142, 32'o04236526362, 32'o10365611275, 32'o07117336710,
		32'o11051276551, 32'o02362132524, 32'o01011540233, 32'o12162531646,
		32'o07056762337, 32'o06631245521, 32'o14164542224, 32'o32633236305,
		32'o23342700176, 32'o02433062234, 32'o15257225043, 32'o26762051606,
		32'o00742573230, 32'o05366042132, 32'o12126416411, 32'o00520471171,
		32'o00725646277, 32'o20116577576, 32'o25765742604, 32'o07633473735,
		32'o15674255275, 32'o17555634041, 32'o06503154145, 32'o21576344247,
		32'o14577627653, 32'o02707523333, 32'o34146376720, 32'o30060227734,
		32'o13765414060, 32'o36072251540, 32'o07255221037, 32'o24364674123,
		32'o06200353166, 32'o10126373326, 32'o15664104320, 32'o16401041535,
		32'o16215305520, 32'o33115351014, 32'o17411670323
	};

	// advance a table position by one with wrap
	function automatic idx_t step_index(input idx_t p);
		return (p == idx_t'(TABLE_DEPTH - 1)) ? '0 : idx_t'(p + idx_t'(1));
	endfunction

endpackage

// ===== design/alfr_mem.sv =====
// Word table: one write port, two registered read ports, reset image via valid bits.
// Depends on alfr_pkg.
`timescale 1ns / 1ps

module alfr_mem (
	input  logic             clk,
	input  logic             arst_n,
	input  alfr_pkg::idx_t   raddr_a,
	input  alfr_pkg::idx_t   raddr_b,
	input  alfr_pkg::mem_wr_t wr,
	output alfr_pkg::word_t  rdata_a,
	output alfr_pkg::word_t  rdata_b
);

	alfr_pkg::word_t mem [alfr_pkg::TABLE_DEPTH];
	logic [alfr_pkg::TABLE_DEPTH-1:0] vld_q;

	alfr_pkg::word_t data_a_q, data_b_q;
	alfr_pkg::idx_t  addr_a_q, addr_b_q;
	logic            hit_a_q, hit_b_q;

	logic fwd_a, fwd_b;

	assign fwd_a = wr.en && (wr.addr == raddr_a);
	assign fwd_b = wr.en && (wr.addr == raddr_b);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		// write-first: a read of the entry being written sees the new word
		data_a_q <= fwd_a ? wr.data : mem[raddr_a];
		data_b_q <= fwd_b ? wr.data : mem[raddr_b];
		addr_a_q <= raddr_a;
		addr_b_q <= raddr_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			hit_a_q <= 1'b0;
			hit_b_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			hit_a_q <= fwd_a || vld_q[raddr_a];
			hit_b_q <= fwd_b || vld_q[raddr_b];
		end
	end

	// never-written entries still hold their reset constant
	assign rdata_a = hit_a_q ? data_a_q : alfr_pkg::RESET_WORDS[addr_a_q];
	assign rdata_b = hit_b_q ? data_b_q : alfr_pkg::RESET_WORDS[addr_b_q];

endmodule

// ===== design/alfr_mod.sv =====
// Remainder of a word by the table depth, pipelined through registers x_q, z_q, q_q and r_q.
// Folds by 2^20 (1 mod 55) down to 20 bits, then a reciprocal multiply. Depends on alfr_pkg.
`timescale 1ns / 1ps

module alfr_mod (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  alfr_pkg::word_t x,
	output logic            busy,
	output alfr_pkg::idx_t  rem
);

	localparam int unsigned FOLD_W   = 20;
	localparam int unsigned RECIP_SH = 26;
	localparam int unsigned RECIP_W  = 21;
	localparam int unsigned PROD_W   = FOLD_W + RECIP_W;
	localparam int unsigned Q_W      = PROD_W - RECIP_SH;
	// ceil(2^26 / 55): exact quotient for every 20-bit input
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_SH) + alfr_pkg::TABLE_DEPTH - 1)
		/ alfr_pkg::TABLE_DEPTH);

	logic [2:0]          stg_q;
	alfr_pkg::word_t     x_q;
	logic [FOLD_W-1:0]   z_q;
	logic [Q_W-1:0]      q_q;
	alfr_pkg::idx_t      r_q;

	logic [FOLD_W:0]     y;
	logic [FOLD_W-1:0]   z;
	logic [PROD_W-1:0]   prod;

	// hi + lo keeps the residue; a second fold clears the carry
	assign y    = {1'b0, x_q[FOLD_W-1:0]} + (FOLD_W+1)'(x_q[alfr_pkg::WORD_W-1:FOLD_W]);
	assign z    = y[FOLD_W-1:0] + FOLD_W'(y[FOLD_W]);
	assign prod = z_q * RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_q <= '0;
		end else begin
			stg_q <= {stg_q[1:0], start};
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
		end
		if (stg_q[0]) begin
			z_q <= z;
		end
		if (stg_q[1]) begin
			q_q <= prod[PROD_W-1:RECIP_SH];
		end
		// remainder fits the low bits, so the subtraction only needs those
		if (stg_q[2]) begin
			r_q <= z_q[alfr_pkg::IDX_W-1:0]
				- alfr_pkg::idx_t'(q_q * alfr_pkg::idx_t'(alfr_pkg::TABLE_DEPTH));
		end
	end

	assign busy = |stg_q;
	assign rem  = r_q;

endmodule

// ===== design/additive_lagged_fibonacci_rng_unit.sv =====
// Draw: accepted in any idle cycle, one per cycle; value strobes via draw_s1, then valid_q.
// Throughput of draws is set by the 2-read/1-write table memory with write-first forwarding.
// Seed: busy while word 0 is added and written back, each later word is read, then added and
// written back, and the positions are loaded; the depth remainder of word 0 runs alongside.
// Reset: table reads as its constant image, positions 0 and the lag, no result pending.
`timescale 1ns / 1ps

module additive_lagged_fibonacci_rng_unit #(
	parameter int unsigned LAG_OFFSET = alfr_pkg::LAG_OFFSET
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        kind,
	input  logic [31:0] seed,
	output logic        busy,
	output logic        valid,
	output logic [31:0] value
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SD_RD = 2'd1;
	localparam logic [1:0] ST_SD_WR = 2'd2;
	localparam logic [1:0] ST_SD_FIN = 2'd3;

	localparam alfr_pkg::idx_t LAST_IDX = alfr_pkg::idx_t'(alfr_pkg::TABLE_DEPTH - 1);

	logic [1:0]      state_q;
	alfr_pkg::idx_t  first_q, second_q, idx_q;
	alfr_pkg::word_t chain_q, prev_q;
	alfr_pkg::idx_t  addr_a_s1;
	logic            draw_s1;
	logic            valid_q;
	alfr_pkg::word_t value_q;

	logic            acc_draw, acc_seed;
	alfr_pkg::idx_t  raddr_a;
	alfr_pkg::word_t rd_a, rd_b, sum, new_word, chain_nx, csum, cdif;
	logic [41:0]     cprod;
	alfr_pkg::mem_wr_t wr;
	logic            mod_start, mod_busy;
	alfr_pkg::idx_t  mod_rem;
	logic [alfr_pkg::IDX_W:0] sec_raw;

	assign busy     = (state_q != ST_IDLE);
	assign acc_draw = start && !busy && kind;
	assign acc_seed = start && !busy && !kind;

	assign raddr_a = (state_q == ST_IDLE) ? (kind ? first_q : '0) : idx_q;

	alfr_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.raddr_a (raddr_a),
		.raddr_b (second_q),
		.wr      (wr),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	assign sum      = rd_a + rd_b;
	assign new_word = rd_a + chain_q;

	// 1001*p + 999*c == 1000*(p + c) + (p - c)
	assign csum     = prev_q + chain_q;
	assign cdif     = prev_q - chain_q;
	assign cprod    = csum * 10'd1000;
	assign chain_nx = cprod[31:0] + cdif;

	always_comb begin
		wr.en   = draw_s1 || (state_q == ST_SD_WR);
		wr.addr = draw_s1 ? addr_a_s1 : idx_q;
		wr.data = draw_s1 ? sum : new_word;
	end

	assign mod_start = (state_q == ST_SD_WR) && (idx_q == '0);

	alfr_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.x      (new_word),
		.busy   (mod_busy),
		.rem    (mod_rem)
	);

	assign sec_raw = {1'b0, mod_rem} + (alfr_pkg::IDX_W+1)'(LAG_OFFSET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			first_q  <= '0;
			second_q <= alfr_pkg::idx_t'(LAG_OFFSET);
			idx_q    <= '0;
			draw_s1  <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			draw_s1 <= acc_draw;
			valid_q <= draw_s1;
			case (state_q)
				ST_IDLE: begin
					if (acc_draw) begin
						first_q  <= alfr_pkg::step_index(first_q);
						second_q <= alfr_pkg::step_index(second_q);
					end else if (acc_seed) begin
						idx_q   <= '0;
						state_q <= ST_SD_WR;
					end
				end
				ST_SD_RD: begin
					state_q <= ST_SD_WR;
				end
				ST_SD_WR: begin
					if (idx_q == LAST_IDX) begin
						state_q <= ST_SD_FIN;
					end else begin
						idx_q   <= idx_q + alfr_pkg::idx_t'(1);
						state_q <= ST_SD_RD;
					end
				end
				ST_SD_FIN: begin
					if (!mod_busy) begin
						first_q  <= mod_rem;
						second_q <= (sec_raw >= (alfr_pkg::IDX_W+1)'(alfr_pkg::TABLE_DEPTH))
							? alfr_pkg::idx_t'(sec_raw - (alfr_pkg::IDX_W+1)'(alfr_pkg::TABLE_DEPTH))
							: sec_raw[alfr_pkg::IDX_W-1:0];
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc_seed) begin
			chain_q <= seed;
		end else if (state_q == ST_SD_RD) begin
			chain_q <= chain_nx;
		end
		if (state_q == ST_SD_WR) begin
			prev_q <= new_word;
		end
		addr_a_s1 <= first_q;
		if (draw_s1) begin
			value_q <= sum;
		end
	end

	assign valid = valid_q;
	assign value = value_q;

endmodule

// ===== design/alfr_chk.sv =====
// Port-level checker for the lagged Fibonacci word source, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module alfr_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        kind,
	input logic [31:0] seed,
	input logic        busy,
	input logic        valid,
	input logic [31:0] value
);

	logic draw_acc, seed_acc;

	assign draw_acc = start && !busy && kind;
	assign seed_acc = start && !busy && !kind;

	`ASSERT_CLK(a_draw_gives_beat, draw_acc |=> ##1 valid, "draw accepted without a result beat")
	`ASSERT_CLK(a_beat_has_draw, valid |-> $past(draw_acc, 2), "result beat without a draw")
	`ASSERT_CLK(a_seed_holds_busy, seed_acc |=> busy, "seed accepted but not busy")
	`ASSERT_CLK_RST(a_beat_in_seed, clk, arst_n, (valid && busy) |-> $rose(busy), "beat deep in seed walk")

endmodule

bind additive_lagged_fibonacci_rng_unit alfr_chk u_alfr_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.kind   (kind),
	.seed   (seed),
	.busy   (busy),
	.valid  (valid),
	.value  (value)
);

// ===== tb/tb_top.sv =====
// Self-checking bench for additive_lagged_fibonacci_rng_unit: seed and draw beats against a
// local table model. Depends on alfr_pkg for the table constants and word types.
`timescale 1ns / 1ps

module tb_top;

	localparam bit          KIND_SEED   = 1'b0;
	localparam bit          KIND_DRAW   = 1'b1;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned MAX_SHOWN   = 10;
	localparam int unsigned DRAIN_WAIT  = 16;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        start  = 1'b0;
	logic        kind   = 1'b0;
	logic [31:0] seed   = '0;
	logic        busy;
	logic        valid;
	logic [31:0] value;

	// model of the word table and its two read positions
	alfr_pkg::word_t rng_table [alfr_pkg::TABLE_DEPTH];
	logic [5:0]      lead_pos;
	logic [5:0]      lag_pos;

	alfr_pkg::word_t expected_words [$];
	int unsigned     draws_sent;
	int unsigned     seeds_sent;
	int unsigned     words_checked;
	int unsigned     mismatches;

	additive_lagged_fibonacci_rng_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.seed   (seed),
		.busy   (busy),
		.valid  (valid),
		.value  (value)
	);

	always #1 clk = ~clk;

	task automatic load_reset_table();
		for (int i = 0; i < alfr_pkg::TABLE_DEPTH; i++) begin
			rng_table[i] = alfr_pkg::RESET_WORDS[i];
		end
		lead_pos = '0;
		lag_pos  = 6'(alfr_pkg::LAG_OFFSET % alfr_pkg::TABLE_DEPTH);
	endtask

	task automatic mix_seed(input alfr_pkg::word_t s);
		alfr_pkg::word_t chain;
		chain = s;
		rng_table[0] = rng_table[0] + s;
		for (int i = 1; i < alfr_pkg::TABLE_DEPTH; i++) begin
			chain        = rng_table[i-1] * 32'd1001 + chain * 32'd999;
			rng_table[i] = rng_table[i] + chain;
		end
		lead_pos = 6'(rng_table[0] % alfr_pkg::TABLE_DEPTH);
		lag_pos  = 6'((lead_pos + alfr_pkg::LAG_OFFSET) % alfr_pkg::TABLE_DEPTH);
	endtask

	function automatic logic [5:0] next_pos(input logic [5:0] p);
		return (p >= alfr_pkg::TABLE_DEPTH - 1) ? 6'd0 : p + 6'd1;
	endfunction

	// both positions stay below the depth, so they index the table directly
	function automatic alfr_pkg::word_t draw_word();
		alfr_pkg::word_t sum;
		sum = rng_table[lead_pos] + rng_table[lag_pos];
		rng_table[lead_pos] = sum;
		lead_pos = next_pos(lead_pos);
		lag_pos  = next_pos(lag_pos);
		return sum;
	endfunction

	task automatic report_mismatch(input string what, input alfr_pkg::word_t want,
		input alfr_pkg::word_t got);
		mismatches++;
		if (mismatches <= MAX_SHOWN) begin
			$display("[%0t] %s: expected %08h, got %08h", $time, what, want, got);
		end
	endtask

	// one beat; start stays high on return so back-to-back beats need no re-raise
	task automatic send_beat(input bit k, input alfr_pkg::word_t s);
		start <= 1'b1;
		kind  <= k;
		seed  <= s;
		do @(posedge clk); while (busy !== 1'b0);
		if (k == KIND_DRAW) begin
			expected_words.push_back(draw_word());
			draws_sent++;
		end else begin
			mix_seed(s);
			seeds_sent++;
		end
	endtask

	// random idle cycles before a beat, with junk on the data lines
	task automatic sender_pause(input int unsigned idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			kind  <= 1'($urandom);
			seed  <= $urandom;
			@(posedge clk);
		end
	endtask

	task automatic test_draws_after_reset();
		repeat (4) send_beat(KIND_DRAW, $urandom);
	endtask

	task automatic test_zero_seed();
		send_beat(KIND_SEED, '0);
		repeat (3) send_beat(KIND_DRAW, '1);
	endtask

	task automatic test_extreme_seeds();
		send_beat(KIND_SEED, '1);
		repeat (2) send_beat(KIND_DRAW, '0);
		send_beat(KIND_SEED, 32'h8000_0000);
		send_beat(KIND_DRAW, $urandom);
		send_beat(KIND_SEED, 32'h0000_0001);
		send_beat(KIND_DRAW, $urandom);
		// seed directly after seed
		send_beat(KIND_SEED, 32'h5555_5555);
		send_beat(KIND_SEED, 32'hAAAA_AAAA);
		repeat (2) send_beat(KIND_DRAW, $urandom);
	endtask

	task automatic test_random_stream(input int unsigned beats, input int unsigned idle_pct);
		alfr_pkg::word_t s;
		bit              k;
		for (int n = 0; n < beats; n++) begin
			sender_pause(idle_pct);
			k = ($urandom_range(99) < 6) ? KIND_SEED : KIND_DRAW;
			case ($urandom_range(7))
				0: s = '0;
				1: s = '1;
				2: s = alfr_pkg::word_t'(1) << $urandom_range(31);
				default: s = $urandom;
			endcase
			send_beat(k, s);
		end
	endtask

	always @(posedge clk) begin : check_beat
		alfr_pkg::word_t want;
		if (arst_n && valid === 1'b1) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected result beat", '0, value);
			end else begin
				want = expected_words.pop_front();
				words_checked++;
				if (value !== want) begin
					report_mismatch("value mismatch", want, value);
				end
			end
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Timeout after %0d cycles, %0d results outstanding",
			CYCLE_LIMIT, expected_words.size());
		$display("Verification failed");
		$finish;
	end

	initial begin
		draws_sent    = 0;
		seeds_sent    = 0;
		words_checked = 0;
		mismatches    = 0;
		load_reset_table();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_draws_after_reset();
		test_zero_seed();
		test_extreme_seeds();
		test_random_stream(445, 6);
		test_random_stream(445, 80);
		test_random_stream(445, 0);

		start <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (expected_words.size() != 0) begin
			mismatches++;
			$display("%0d expected results never arrived", expected_words.size());
		end

		$display("Ran %0d seed beats and %0d draw beats; %0d result words checked",
			seeds_sent, draws_sent, words_checked);
		$display("Sender gap mix: light, heavy, none; %0d mismatches", mismatches);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/alfr_pkg.sv
design/alfr_mem.sv
design/alfr_mod.sv
design/additive_lagged_fibonacci_rng_unit.sv
design/alfr_chk.sv
tb/tb_top.sv
